### design/packet_ring_fifo_overwrite_macros.svh
// Assertion macros shared by the packet ring FIFO modules.
`ifndef PACKET_RING_FIFO_OVERWRITE_MACROS_SVH
`define PACKET_RING_FIFO_OVERWRITE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PRFO_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prfo assertion failed");
// Next-cycle implication, checked outside reset.
`define PRFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prfo assertion failed");
`else
`define PRFO_ASSERT(label, clk, rst, ante, cons)
`define PRFO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/prfo_pkg.sv
// Types and constants shared by the packet ring FIFO modules.
package prfo_pkg;

  localparam int DATA_W = 8;
  localparam int HIDX_W = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Result kind as seen on the output tuser.
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_EMPTY  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              accepted;
    logic              overwrote;
    logic              truncated;
    logic [HIDX_W-1:0] head_idx;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_LEN    = 2'd1,
    BK_STREAM = 2'd2
  } bk_state_t;

endpackage

### design/prfo_ram.sv
// Generic simple dual-port RAM with registered read.
module prfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/prfo_queue.sv
// Two-entry request queue between the front and the back.
module prfo_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int DEPTH = 2;

  logic [W-1:0] mem [DEPTH];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign ready = cnt != 2'(DEPTH);
  assign valid = cnt != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/prfo_front.sv
// Front end: accepts items, stores packet bytes, decides commits, queues results.
`include "packet_ring_fifo_overwrite_macros.svh"
module prfo_front #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64,
  localparam int SLOT_W    = $clog2(SLOTS),
  localparam int IDX_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int CNT_W     = $clog2(SLOT_BYTES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [15:0]             s_tdata,
  input  logic                    s_tuser,
  input  logic                    s_tlast,
  input  logic                    q_ready,
  output logic                    q_push,
  output prfo_pkg::req_t          q_req,
  output logic [SLOT_W-1:0]       q_slot,
  output logic                    pk_we,
  output logic [SLOT_W+IDX_W-1:0] pk_waddr,
  output logic [7:0]              pk_wdata,
  output logic                    len_we,
  output logic [SLOT_W-1:0]       len_waddr,
  output logic [CNT_W-1:0]        len_wdata,
  input  logic                    done
);

  localparam int HW = prfo_pkg::HIDX_W;

  logic [SLOT_W-1:0] head, head_next;
  logic [SLOT_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic              trunc, trunc_next;
  logic [1:0]        rd_cnt, rd_cnt_next;

  logic              is_write;
  logic              acc;
  logic              room;
  logic              is_free;
  logic              commit;
  logic              rd_inc;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_inc;
  logic [SLOT_W-1:0] head_after;
  logic [CNT_W-1:0]  fill_upd;
  logic              trunc_upd;

  assign is_write   = s_tuser == prfo_pkg::CMD_WRITE;
  // hold writes while any read still fetches from the ring
  assign s_tready   = q_ready && !(is_write && rd_cnt != 2'd0);
  assign acc        = s_tvalid && s_tready;
  assign room       = fill < CNT_W'(SLOT_BYTES);
  assign head_inc   = (head == SLOT_W'(SLOTS - 1)) ? '0 : head + SLOT_W'(1);
  assign tail_inc   = (tail == SLOT_W'(SLOTS - 1)) ? '0 : tail + SLOT_W'(1);
  assign is_free    = head_inc != tail;
  assign commit     = is_free || s_tdata[8];
  assign head_after = commit ? head_inc : head;
  assign fill_upd   = room ? fill + CNT_W'(1) : fill;
  assign trunc_upd  = trunc || !room;

  assign pk_we     = acc && is_write && room;
  assign pk_waddr  = {head, fill[IDX_W-1:0]};
  assign pk_wdata  = s_tdata[7:0];
  assign len_we    = acc && is_write && s_tlast && commit;
  assign len_waddr = head;
  assign len_wdata = fill_upd;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    trunc_next = trunc;
    q_push     = 1'b0;
    q_req      = '0;
    q_slot     = tail;
    rd_inc     = 1'b0;
    if (acc) begin
      if (is_write) begin
        fill_next  = fill_upd;
        trunc_next = trunc_upd;
        if (s_tlast) begin
          q_push          = 1'b1;
          q_req.op        = prfo_pkg::OP_STATUS;
          q_req.accepted  = commit;
          q_req.overwrote = !is_free && s_tdata[8];
          q_req.truncated = trunc_upd;
          q_req.head_idx  = HW'(head_after);
          head_next       = head_after;
          if (commit && !is_free) begin
            tail_next = tail_inc;
          end
          fill_next  = '0;
          trunc_next = 1'b0;
        end
      end else begin
        q_push = 1'b1;
        if (tail == head) begin
          q_req.op = prfo_pkg::OP_EMPTY;
        end else begin
          q_req.op  = prfo_pkg::OP_READ;
          rd_inc    = 1'b1;
          tail_next = tail_inc;
        end
      end
    end
    rd_cnt_next = rd_cnt + 2'(rd_inc) - 2'(done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
      trunc  <= 1'b0;
      rd_cnt <= 2'd0;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      fill   <= fill_next;
      trunc  <= trunc_next;
      rd_cnt <= rd_cnt_next;
    end
  end

  `PRFO_ASSERT(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(SLOT_BYTES))
  `PRFO_ASSERT_NEXT(a_commit_nonempty, clk, rst, len_we, head != tail)
  `PRFO_ASSERT(a_done_counted, clk, rst, done, rd_cnt != 2'd0)

endmodule

### design/prfo_back.sv
// Back end: turns queued requests into result items, streaming packets from the ring.
`include "packet_ring_fifo_overwrite_macros.svh"
module prfo_back #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64,
  localparam int SLOT_W    = $clog2(SLOTS),
  localparam int IDX_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int CNT_W     = $clog2(SLOT_BYTES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  prfo_pkg::req_t          q_req,
  input  logic [SLOT_W-1:0]       q_slot,
  output logic                    len_re,
  output logic [SLOT_W-1:0]       len_raddr,
  input  logic [CNT_W-1:0]        len_rdata,
  output logic                    pk_re,
  output logic [SLOT_W+IDX_W-1:0] pk_raddr,
  input  logic [7:0]              pk_rdata,
  output logic                    done,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [15:0]             m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  localparam int HW = prfo_pkg::HIDX_W;

  prfo_pkg::bk_state_t state, state_next;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    len;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    idx_inc;
  logic                pend;
  logic                pend_last;
  logic                out_valid;
  prfo_pkg::kind_t     out_kind;
  logic [7:0]          out_data;
  logic                out_last;
  logic                out_acc;
  logic                out_ovw;
  logic                out_trn;
  logic [HW-1:0]       out_hidx;

  logic out_free;
  logic move;
  logic issue;
  logic load_status;

  assign out_free  = !out_valid || m_tready;
  assign move      = pend && out_free;
  assign idx_inc   = idx + CNT_W'(1);
  assign len_raddr = q_slot;
  assign pk_raddr  = {slot, idx[IDX_W-1:0]};

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    len_re      = 1'b0;
    pk_re       = 1'b0;
    done        = 1'b0;
    issue       = 1'b0;
    load_status = 1'b0;
    case (state)
      prfo_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_req.op == prfo_pkg::OP_READ) begin
            q_pop      = 1'b1;
            len_re     = 1'b1;
            state_next = prfo_pkg::BK_LEN;
          end else if (!pend && out_free) begin
            q_pop       = 1'b1;
            load_status = 1'b1;
          end
        end
      end
      prfo_pkg::BK_LEN: begin
        state_next = prfo_pkg::BK_STREAM;
      end
      prfo_pkg::BK_STREAM: begin
        // fetch the next byte once the fetched one can move on
        if (!pend || out_free) begin
          issue = 1'b1;
          pk_re = 1'b1;
          if (idx_inc == len) begin
            done       = 1'b1;
            state_next = prfo_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = prfo_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prfo_pkg::BK_IDLE;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == prfo_pkg::BK_LEN) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx_inc;
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move || load_status) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot <= q_slot;
    end
    if (state == prfo_pkg::BK_LEN) begin
      len <= len_rdata;
    end
    if (issue) begin
      pend_last <= idx_inc == len;
    end
    if (move) begin
      out_kind <= prfo_pkg::KIND_BYTE;
      out_data <= pk_rdata;
      out_last <= pend_last;
      out_acc  <= 1'b0;
      out_ovw  <= 1'b0;
      out_trn  <= 1'b0;
      out_hidx <= '0;
    end else if (load_status) begin
      out_kind <= (q_req.op == prfo_pkg::OP_EMPTY) ? prfo_pkg::KIND_EMPTY
                                                   : prfo_pkg::KIND_STATUS;
      out_data <= '0;
      out_last <= 1'b0;
      out_acc  <= q_req.accepted;
      out_ovw  <= q_req.overwrote;
      out_trn  <= q_req.truncated;
      out_hidx <= q_req.head_idx;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_hidx, out_trn, out_ovw, out_acc, out_data};

  `PRFO_ASSERT(a_idx_range, clk, rst, state == prfo_pkg::BK_STREAM, idx < len)
  `PRFO_ASSERT(a_len_nonzero, clk, rst, state == prfo_pkg::BK_STREAM, len != '0)
  `PRFO_ASSERT_NEXT(a_pend_hold, clk, rst, pend && !out_free, pend)

endmodule

### design/packet_ring_fifo_overwrite.sv
// Packet ring FIFO that overwrites the oldest packet: top level.
//
// Slave stream s_*: one request per beat. s_tuser is the command (0 writes one
// packet byte, 1 reads the oldest packet), s_tlast marks the final byte of a
// written packet, s_tdata carries the byte and the force bit.
// Master stream m_*: result items. m_tuser is the kind (commit status, read
// byte, ring empty), m_tlast marks the final byte of a read packet.
// Write bytes are taken one per cycle while s_tready is high; a non-final byte gives
// no result. The final byte gives a commit status through the request queue and the
// output register. A read passes the queue, a length RAM read and packet RAM reads,
// then gives one byte per cycle for the packet length while m_tready allows, paced
// by the packet RAM read port; an empty ring gives one result through the queue.
// Write requests wait while a read request still fetches bytes from the ring,
// so a slot is never refilled under a running read. Read and status requests
// pass through a two-entry queue, so the front keeps taking requests while the
// output register waits on m_tready; a full queue holds s_tready low.
// Reset empties the ring and drops any partial packet; the RAM needs no
// clearing pass and the block takes requests in the cycle after reset.
module packet_ring_fifo_overwrite #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_in, [8] force_req, rest zero
  input  logic        s_tuser,   // [0] cmd
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_out, [8] accepted, [9] overwrote,
                                 // [10] truncated, [13:11] head_index, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int REQ_W  = $bits(prfo_pkg::req_t);
  localparam int Q_W    = REQ_W + SLOT_W;

  prfo_pkg::req_t          f_req;
  logic [SLOT_W-1:0]       f_slot;
  logic                    q_push;
  logic                    q_ready;
  logic                    q_valid;
  logic                    q_pop;
  logic [Q_W-1:0]          q_rdata;
  prfo_pkg::req_t          b_req;
  logic [SLOT_W-1:0]       b_slot;
  logic                    pk_we;
  logic [SLOT_W+IDX_W-1:0] pk_waddr;
  logic [7:0]              pk_wdata;
  logic                    pk_re;
  logic [SLOT_W+IDX_W-1:0] pk_raddr;
  logic [7:0]              pk_rdata;
  logic                    len_we;
  logic [SLOT_W-1:0]       len_waddr;
  logic [CNT_W-1:0]        len_wdata;
  logic                    len_re;
  logic [SLOT_W-1:0]       len_raddr;
  logic [CNT_W-1:0]        len_rdata;
  logic                    done;

  assign b_req  = q_rdata[REQ_W-1:0];
  assign b_slot = q_rdata[Q_W-1:REQ_W];

  prfo_front #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_req     (f_req),
    .q_slot    (f_slot),
    .pk_we     (pk_we),
    .pk_waddr  (pk_waddr),
    .pk_wdata  (pk_wdata),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .done      (done)
  );

  prfo_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_slot, f_req}),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  prfo_ram #(
    .WIDTH (8),
    .DEPTH (SLOTS << IDX_W)
  ) u_packet_ram (
    .clk   (clk),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata),
    .re    (pk_re),
    .raddr (pk_raddr),
    .rdata (pk_rdata)
  );

  prfo_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SLOTS)
  ) u_length_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  prfo_back #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (b_req),
    .q_slot    (b_slot),
    .len_re    (len_re),
    .len_raddr (len_raddr),
    .len_rdata (len_rdata),
    .pk_re     (pk_re),
    .pk_raddr  (pk_raddr),
    .pk_rdata  (pk_rdata),
    .done      (done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### tb/tb_packet_ring_fifo_overwrite.sv
// Testbench for the packet ring FIFO with overwrite: stream stimulus, in-line predictor, checker.
`timescale 1ns / 100ps

module tb_packet_ring_fifo_overwrite;

  localparam int NSLOTS      = 8;
  localparam int NBYTES      = 64;
  localparam int ITEM_TARGET = 460;

  typedef struct {
    prfo_pkg::kind_t             kind;
    logic [prfo_pkg::DATA_W-1:0] data;
    logic                        last;
    logic                        accepted;
    logic                        overwrote;
    logic                        truncated;
    logic [prfo_pkg::HIDX_W-1:0] head_idx;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] data_in, [8] force_req, rest zero
  logic        s_tuser = prfo_pkg::CMD_WRITE;  // [0] cmd
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] data_out, [8] accepted, [9] overwrote,
                               // [10] truncated, [13:11] head_index, rest zero
  logic [1:0]  m_tuser;        // [1:0] kind
  logic        m_tlast;

  // Predicted ring contents
  logic [prfo_pkg::HIDX_W-1:0] ring_head;
  logic [prfo_pkg::HIDX_W-1:0] ring_tail;
  int                          ring_fill;
  logic                        ring_trunc;
  logic [prfo_pkg::DATA_W-1:0] ring_bytes [NSLOTS][NBYTES];
  int                          ring_len [NSLOTS];

  ring_result_t pending_results [$];
  ring_result_t seen_want;
  int           mismatches = 0;
  int           items_sent = 0;
  bit           gaps_on = 1'b1;

  packet_ring_fifo_overwrite #(
    .SLOTS      (NSLOTS),
    .SLOT_BYTES (NBYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [prfo_pkg::HIDX_W-1:0] next_slot(
      logic [prfo_pkg::HIDX_W-1:0] s);
    return (s == NSLOTS - 1) ? '0 : s + 1'b1;
  endfunction

  // Update the predicted ring for one accepted request and queue its results.
  function automatic void ring_apply(logic cmd, logic [prfo_pkg::DATA_W-1:0] data,
                                     logic last, logic force_bit);
    ring_result_t r;
    logic         is_free;
    logic         commit;
    int           n;
    r = '{kind: prfo_pkg::KIND_STATUS, data: '0, last: 1'b0, accepted: 1'b0,
          overwrote: 1'b0, truncated: 1'b0, head_idx: '0};
    if (cmd == prfo_pkg::CMD_WRITE) begin
      if (ring_fill < NBYTES) begin
        ring_bytes[ring_head][ring_fill] = data;
        ring_fill++;
      end else begin
        ring_trunc = 1'b1;
      end
      if (!last) return;
      is_free = next_slot(ring_head) != ring_tail;
      commit  = is_free || force_bit;
      if (commit) begin
        ring_len[ring_head] = ring_fill;
        ring_head = next_slot(ring_head);
        if (!is_free) ring_tail = next_slot(ring_tail);
      end
      r.accepted  = commit;
      r.overwrote = !is_free && force_bit;
      r.truncated = ring_trunc;
      r.head_idx  = ring_head;
      pending_results.push_back(r);
      ring_fill  = 0;
      ring_trunc = 1'b0;
    end else if (ring_head == ring_tail) begin
      r.kind = prfo_pkg::KIND_EMPTY;
      pending_results.push_back(r);
    end else begin
      n = ring_len[ring_tail];
      r.kind = prfo_pkg::KIND_BYTE;
      for (int i = 0; i < n; i++) begin
        r.data = ring_bytes[ring_tail][i];
        r.last = (i == n - 1);
        pending_results.push_back(r);
      end
      ring_tail = next_slot(ring_tail);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0h, want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Present one request, hold it until taken, then predict.
  task automatic send_item(logic cmd, logic [prfo_pkg::DATA_W-1:0] data, logic last,
                           logic force_bit);
    if (gaps_on) begin
      while ($urandom_range(99) < 25) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, force_bit, data};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    ring_apply(cmd, data, last, force_bit);
    items_sent++;
  endtask

  task automatic send_read();
    send_item(prfo_pkg::CMD_READ, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Bytes are random; force only matters on the final byte, but vary it throughout.
  task automatic write_packet(int len, logic force_bit);
    for (int i = 0; i < len; i++)
      send_item(prfo_pkg::CMD_WRITE, 8'($urandom), i == len - 1,
                (i == len - 1) ? force_bit : 1'($urandom));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(4, 1);
    if (r < 88) return $urandom_range(20, 5);
    if (r < 96) return $urandom_range(NBYTES, 21);
    return $urandom_range(NBYTES + 5, NBYTES + 1);
  endfunction

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic empty_ring();
    while (ring_head != ring_tail) send_read();
    send_read();
  endtask

  task automatic test_directed();
    send_item(prfo_pkg::CMD_READ, 8'hA5, 1'b1, 1'b1);      // read of an empty ring
    send_item(prfo_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0);
    send_item(prfo_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b1);     // force with a free slot
    send_read();
    send_read();
    // fill every usable slot, then discard and overwrite
    for (int i = 0; i < NSLOTS - 1; i++) write_packet(1 + (i % 2), 1'b0);
    write_packet(1, 1'b0);
    write_packet(2, 1'b1);
    // read while a packet is half written
    send_item(prfo_pkg::CMD_WRITE, 8'h3C, 1'b0, 1'b1);
    send_read();
    send_item(prfo_pkg::CMD_WRITE, 8'hC3, 1'b1, 1'b0);
    drain_results();
    empty_ring();
  endtask

  task automatic test_long_packets();
    write_packet(NBYTES, 1'b0);
    write_packet(NBYTES + 1, 1'b0);              // final byte dropped
    write_packet(NBYTES + 3, 1'b1);
    empty_ring();
    drain_results();
  endtask

  task automatic test_random_traffic(int stop_at);
    int r;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        write_packet(pick_len(), 1'($urandom));
      end else if (r < 88) begin
        send_read();
      end else begin
        // broken-up write: a read lands between the bytes of one packet
        write_packet(0, 1'b0);
        for (int i = 0; i < $urandom_range(3, 1); i++)
          send_item(prfo_pkg::CMD_WRITE, 8'($urandom), 1'b0, 1'($urandom));
        send_read();
        send_item(prfo_pkg::CMD_WRITE, 8'($urandom), 1'b1, 1'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back(int stop_at);
    gaps_on = 1'b0;
    test_random_traffic(stop_at);
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        seen_want = pending_results.pop_front();
        if (m_tuser !== seen_want.kind) report_mismatch("kind", m_tuser, seen_want.kind);
        if (m_tdata[7:0] !== seen_want.data)
          report_mismatch("data_out", m_tdata[7:0], seen_want.data);
        if (m_tlast !== seen_want.last) report_mismatch("last_out", m_tlast, seen_want.last);
        if (m_tdata[8] !== seen_want.accepted)
          report_mismatch("accepted", m_tdata[8], seen_want.accepted);
        if (m_tdata[9] !== seen_want.overwrote)
          report_mismatch("overwrote", m_tdata[9], seen_want.overwrote);
        if (m_tdata[10] !== seen_want.truncated)
          report_mismatch("truncated", m_tdata[10], seen_want.truncated);
        if (m_tdata[13:11] !== seen_want.head_idx)
          report_mismatch("head_index", m_tdata[13:11], seen_want.head_idx);
        if (m_tdata[15:14] !== 2'b00) report_mismatch("tdata padding", m_tdata[15:14], 0);
      end
    end
    m_tready <= gaps_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  initial begin
    ring_head  = '0;
    ring_tail  = '0;
    ring_fill  = 0;
    ring_trunc = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_packets();
    test_random_traffic(220);
    drain_results();
    test_back_to_back(320);
    test_random_traffic(ITEM_TARGET);
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
